// File: design/hlcs_pkg.sv
// hlcs_pkg: shared types and constants for the hybrid logical clock stamp block
// item structs for both channels, configuration register layout and codes
// no dependencies
`default_nettype none

package hlcs_pkg;

  localparam int TIME_SHIFT_W   = 41;
  localparam int LOG_INTERVAL_W = 36;
  localparam int CFG_DATA_W     = 41;
  localparam int CFG_INDEX_W    = 2;
  localparam int STAMP_W        = 64;

  localparam logic [LOG_INTERVAL_W-1:0] LOG_INTERVAL_RESET = 36'd5000000000;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TIME_SHIFT   = 2'd0,
    REG_WAL_ENABLE   = 2'd1,
    REG_LOG_INTERVAL = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [TIME_SHIFT_W-1:0]   time_shift_ns;
    logic                      wal_enable;
    logic [LOG_INTERVAL_W-1:0] log_interval_ns;
  } cfg_t;

  typedef struct packed {
    logic [63:0] now_ns;
    logic        remote_present;
    logic [63:0] remote_stamp;
  } in_item_t;

  typedef struct packed {
    logic [63:0] hlc;
    logic        log_request;
    logic [63:0] max_issued_out;
  } out_item_t;

endpackage

`default_nettype wire

// File: design/hlcs_fifo.sv
// hlcs_fifo: small register queue with first-word fall-through read
// accepts a write while full when the head is read in the same cycle
// no package dependency
`default_nettype none

module hlcs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  full,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_rd   = rd_en && !empty;
  assign do_wr   = wr_en && (!full || do_rd);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/hlcs_front.sv
// hlcs_front: input side, applies the clock offset and unpacks the remote stamp
// classified items wait in a short queue for the back end
// depends on hlcs_pkg and hlcs_fifo
`default_nettype none

module hlcs_front #(
  parameter int PHYS_BITS    = 48,
  parameter int LOGICAL_BITS = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      push,
  input  wire hlcs_pkg::in_item_t                        req,
  output logic                                           full,
  input  wire hlcs_pkg::cfg_t                            cfg,
  output logic                                           mid_valid,
  output logic [2*PHYS_BITS+LOGICAL_BITS:0]              mid_data,
  input  wire logic                                      mid_take
);

  localparam int MW    = 2 * PHYS_BITS + LOGICAL_BITS + 1;
  localparam int EXT_W = 64 + PHYS_BITS + LOGICAL_BITS;

  logic [63:0]           shift64;
  logic [63:0]           sum64;
  logic [EXT_W-1:0]      remote_ext;
  logic [PHYS_BITS-1:0]  now_phys;
  logic [PHYS_BITS-1:0]  rem_phys;
  logic [LOGICAL_BITS-1:0] rem_log;
  logic [MW-1:0]         item_vec;
  logic                  mid_empty;

  // offset wraps modulo 2^64, only the physical bits survive
  assign shift64  = {{(64 - hlcs_pkg::TIME_SHIFT_W){cfg.time_shift_ns[hlcs_pkg::TIME_SHIFT_W-1]}},
                     cfg.time_shift_ns};
  assign sum64    = req.now_ns + shift64;
  assign now_phys = sum64[PHYS_BITS-1:0];

  // bits above the 64-bit stamp read as zero
  assign remote_ext = EXT_W'(req.remote_stamp);
  assign rem_phys   = remote_ext[LOGICAL_BITS +: PHYS_BITS];
  assign rem_log    = req.remote_stamp[LOGICAL_BITS-1:0];

  assign item_vec = {req.remote_present, rem_phys, rem_log, now_phys};

  hlcs_fifo #(
    .WIDTH (MW),
    .DEPTH (2)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push && !full),
    .wr_data (item_vec),
    .rd_en   (mid_take),
    .rd_data (mid_data),
    .full    (full),
    .empty   (mid_empty)
  );

  assign mid_valid = !mid_empty;

endmodule

`default_nettype wire

// File: design/hlcs_back.sv
// hlcs_back: clock merge stage, issue tracking stage and result queue
// stage a updates physical time and logical count, stage b tracks max and horizon
// depends on hlcs_pkg and hlcs_fifo
`default_nettype none

module hlcs_back #(
  parameter int PHYS_BITS    = 48,
  parameter int LOGICAL_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire hlcs_pkg::cfg_t                    cfg,
  input  wire logic                              mid_valid,
  input  wire logic [2*PHYS_BITS+LOGICAL_BITS:0] mid_data,
  output logic                                   mid_take,
  output logic                                   empty,
  input  wire logic                              pop,
  output hlcs_pkg::out_item_t                    rsp
);

  localparam int P     = PHYS_BITS;
  localparam int L     = LOGICAL_BITS;
  localparam int MW    = 2 * P + L + 1;
  localparam int SW    = P + L;
  localparam int HW    = ((P > hlcs_pkg::LOG_INTERVAL_W) ? P : hlcs_pkg::LOG_INTERVAL_W) + 1;
  localparam int OW    = $bits(hlcs_pkg::out_item_t);

  function automatic logic [63:0] pack_stamp(input logic [P-1:0] p, input logic [L-1:0] l);
    logic [SW+63:0] ext;
    ext = (SW + 64)'({p, l});
    return ext[63:0];
  endfunction

  // unpacked queue head
  logic [P-1:0] a_now;
  logic [P-1:0] a_rphys;
  logic [L-1:0] a_rlog;
  logic         a_remote;

  // stage a state
  logic [P-1:0] phys_time;
  logic [L-1:0] logical_count;
  logic [P-1:0] p_max;
  logic         eq_own;
  logic         eq_rem;
  logic [L-1:0] l_base;
  logic         l_bump;
  logic [L:0]   l_sum;
  logic [P-1:0] p_new;
  logic [L-1:0] l_new;
  logic         a_fire;

  // stage b
  logic         b_valid;
  logic [P-1:0] b_phys;
  logic [L-1:0] b_log;
  logic [63:0]  b_stamp;
  logic [63:0]  max_issued;
  logic [63:0]  max_next;
  logic [63:0]  logged_horizon;
  logic         b_req;
  logic [HW-1:0] hp_sum;
  logic [P-1:0] hp_sat;
  logic         b_fire;

  logic         out_full;
  logic         out_room;
  logic [OW-1:0] out_vec;
  logic [OW-1:0] out_rd;

  assign a_now    = mid_data[P-1:0];
  assign a_rlog   = mid_data[P +: L];
  assign a_rphys  = mid_data[P+L +: P];
  assign a_remote = mid_data[MW-1];

  assign out_room = !out_full || (pop && !empty);
  assign b_fire   = b_valid && out_room;
  assign a_fire   = mid_valid && (!b_valid || b_fire);
  assign mid_take = a_fire;

  always_comb begin
    p_max = (a_now > phys_time) ? a_now : phys_time;
    if (a_remote && (a_rphys > p_max)) begin
      p_max = a_rphys;
    end
    eq_own = (p_max == phys_time);
    eq_rem = a_remote && (p_max == a_rphys);
    l_bump = 1'b1;
    priority if (eq_own && eq_rem) begin
      l_base = (logical_count > a_rlog) ? logical_count : a_rlog;
    end else if (eq_own) begin
      l_base = logical_count;
    end else if (eq_rem) begin
      l_base = a_rlog;
    end else begin
      l_base = '0;
      l_bump = 1'b0;
    end
    l_sum = {1'b0, l_base} + (L + 1)'(l_bump);
    // logical overflow moves physical time on
    if (l_sum[L]) begin
      p_new = p_max + 1'b1;
      l_new = '0;
    end else begin
      p_new = p_max;
      l_new = l_sum[L-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phys_time     <= '0;
      logical_count <= '0;
      b_valid       <= 1'b0;
    end else begin
      if (a_fire) begin
        phys_time     <= p_new;
        logical_count <= l_new;
      end
      if (a_fire) begin
        b_valid <= 1'b1;
      end else if (b_fire) begin
        b_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      b_phys  <= p_new;
      b_log   <= l_new;
      b_stamp <= pack_stamp(p_new, l_new);
    end
  end

  always_comb begin
    max_next = (b_stamp > max_issued) ? b_stamp : max_issued;
    b_req    = cfg.wal_enable && (b_stamp > logged_horizon);
    hp_sum   = HW'(b_phys) + HW'(cfg.log_interval_ns);
    hp_sat   = (|hp_sum[HW-1:P]) ? '1 : hp_sum[P-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_issued     <= '0;
      logged_horizon <= '0;
    end else if (b_fire) begin
      max_issued <= max_next;
      if (b_req) begin
        logged_horizon <= pack_stamp(hp_sat, b_log);
      end
    end
  end

  assign out_vec = {b_stamp, b_req, max_next};

  hlcs_fifo #(
    .WIDTH (OW),
    .DEPTH (2)
  ) u_result_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (b_fire),
    .wr_data (out_vec),
    .rd_en   (pop),
    .rd_data (out_rd),
    .full    (out_full),
    .empty   (empty)
  );

  assign rsp = hlcs_pkg::out_item_t'(out_rd);

endmodule

`default_nettype wire

// File: design/hybrid_logical_clock_stamp.sv
// hybrid_logical_clock_stamp: issues hybrid logical clock timestamps
// top level: configuration registers, front end and back end
// depends on hlcs_pkg, hlcs_front, hlcs_back and hlcs_fifo
//
// usage
// - input channel is a queue: an item (now_ns, remote_present, remote_stamp)
//   is taken at a clock edge with push high and full low
// - result channel is a queue: the oldest stamp sits on rsp while empty is
//   low and leaves at an edge with pop high
// - configuration: cfg_we writes cfg_wdata into register cfg_index at once
//   (clock offset, log enable, log interval); write only while idle
// - path: an item taken at an edge passes the input queue, the clock merge
//   stage and the issue tracking stage before it shows on rsp
// - throughput: one item per cycle sustained while the receiver pops; the
//   bound is the clock merge stage's merge of physical time and logical count
// - a stalled receiver fills the two-entry result queue, then the issue
//   tracking stage, then the two-entry input queue, after which full rises;
//   nothing is lost
// - reset clears the clock state, max issued and log horizon to zero, the
//   offset and log enable to zero and the log interval to five seconds
`default_nettype none

module hybrid_logical_clock_stamp #(
  parameter int PHYS_BITS    = 48,
  parameter int LOGICAL_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // input channel
  input  wire logic                                  push,
  output logic                                       full,
  input  wire hlcs_pkg::in_item_t                    req,
  // result channel
  output logic                                       empty,
  input  wire logic                                  pop,
  output hlcs_pkg::out_item_t                        rsp,
  // configuration write port
  input  wire logic                                  cfg_we,
  input  wire logic [hlcs_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [hlcs_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int MW = 2 * PHYS_BITS + LOGICAL_BITS + 1;

  hlcs_pkg::cfg_t  cfg;
  logic            mid_valid;
  logic [MW-1:0]   mid_data;
  logic            mid_take;

  // configuration registers, writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.time_shift_ns   <= '0;
      cfg.wal_enable      <= 1'b0;
      cfg.log_interval_ns <= hlcs_pkg::LOG_INTERVAL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hlcs_pkg::REG_TIME_SHIFT:   cfg.time_shift_ns <= cfg_wdata;
        hlcs_pkg::REG_WAL_ENABLE:   cfg.wal_enable    <= cfg_wdata[0];
        hlcs_pkg::REG_LOG_INTERVAL: begin
          cfg.log_interval_ns <= cfg_wdata[hlcs_pkg::LOG_INTERVAL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // offset and remote unpack, then the input queue
  hlcs_front #(
    .PHYS_BITS    (PHYS_BITS),
    .LOGICAL_BITS (LOGICAL_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .req       (req),
    .full      (full),
    .cfg       (cfg),
    .mid_valid (mid_valid),
    .mid_data  (mid_data),
    .mid_take  (mid_take)
  );

  // clock merge, issue tracking and result queue
  hlcs_back #(
    .PHYS_BITS    (PHYS_BITS),
    .LOGICAL_BITS (LOGICAL_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .mid_valid (mid_valid),
    .mid_data  (mid_data),
    .mid_take  (mid_take),
    .empty     (empty),
    .pop       (pop),
    .rsp       (rsp)
  );

  // the running maximum always covers the stamp it travels with
  a_max_covers_stamp : assert property (@(posedge clk) disable iff (rst)
    !empty |-> (rsp.max_issued_out >= rsp.hlc))
    else $error("max issued below its own stamp");

  // a log request only leaves while logging is enabled
  a_req_needs_enable : assert property (@(posedge clk) disable iff (rst)
    (!empty && rsp.log_request) |-> cfg.wal_enable)
    else $error("log request with logging disabled");

  // the input queue only fills through a push
  a_full_needs_push : assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push))
    else $error("input queue filled without a push");

endmodule

`default_nettype wire
